FILE: hw/rtl/abt_pkg.sv
// Shared types and constants for the armed boiler thermostat.
package abt_pkg;

  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 19;
  localparam int TEMP_OUT_W = 16;
  localparam int LEVEL_W    = 10;
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 32;
  localparam int NUM_PROBES = 6;

  localparam logic [LEVEL_W-1:0] SWITCH_PRESSED_BELOW = LEVEL_W'(300);
  localparam logic [TIME_W-1:0]  DEBOUNCE_MS          = TIME_W'(333);

  // temp = (raw * 3.3 / 2^ADC_BITS - 0.5) * 10000, kept exact in fixed point
  localparam int TEMP_SCALE  = 33000;
  localparam int TEMP_OFFSET = 5000;

  localparam logic signed [TEMP_W-1:0] BOILER_SP_RESET   = 19'sd120500;
  localparam logic signed [TEMP_W-1:0] LEFT_SP_RESET     = 19'sd10000;
  localparam logic signed [TEMP_W-1:0] RIGHT_SP_RESET    = 19'sd10000;
  localparam logic signed [TEMP_W-1:0] ERROR_LIMIT_RESET = 19'sd250000;
  localparam logic [TIME_W-1:0]        MAX_ARMED_RESET   = TIME_W'(3600000 * 8);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BOILER_SP   = 3'd0,
    REG_LEFT_SP     = 3'd1,
    REG_RIGHT_SP    = 3'd2,
    REG_ERROR_LIMIT = 3'd3,
    REG_MAX_ARMED   = 3'd4
  } reg_idx_t;

endpackage

FILE: hw/rtl/abt_in_if.sv
// Input channel carrying one control tick: timestamp, switch level and probe readings.
interface abt_in_if import abt_pkg::*; #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [LEVEL_W-1:0]  switch_level;
  logic [ADC_BITS-1:0] boiler_raw;
  logic [ADC_BITS-1:0] left_group_raw;
  logic [ADC_BITS-1:0] right_group_raw;
  logic [ADC_BITS-1:0] case_upper_raw;
  logic [ADC_BITS-1:0] case_lower_raw;
  logic [ADC_BITS-1:0] outside_raw;

  modport source (
    output valid, now_ms, switch_level, boiler_raw, left_group_raw, right_group_raw,
           case_upper_raw, case_lower_raw, outside_raw,
    input  ready
  );
  modport sink (
    input  valid, now_ms, switch_level, boiler_raw, left_group_raw, right_group_raw,
           case_upper_raw, case_lower_raw, outside_raw,
    output ready
  );
endinterface

FILE: hw/rtl/abt_out_if.sv
// Output channel carrying one thermostat result per tick.
interface abt_out_if import abt_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic                         heater_on;
  logic                         is_armed;
  logic                         is_active;
  logic                         boiler_ready;
  logic                         left_ready;
  logic                         right_ready;
  logic                         system_ready;
  logic                         sensor_fault;
  logic [TIME_W-1:0]            armed_elapsed_ms;
  logic [TIME_W-1:0]            heater_total_ms;
  logic signed [TEMP_OUT_W-1:0] boiler_temp;

  modport source (
    output valid, heater_on, is_armed, is_active, boiler_ready, left_ready, right_ready,
           system_ready, sensor_fault, armed_elapsed_ms, heater_total_ms, boiler_temp,
    input  ready
  );
  modport sink (
    input  valid, heater_on, is_armed, is_active, boiler_ready, left_ready, right_ready,
           system_ready, sensor_fault, armed_elapsed_ms, heater_total_ms, boiler_temp,
    output ready
  );
endinterface

FILE: hw/rtl/armed_boiler_thermostat_unit.sv
// Armed boiler thermostat: arm control, probe checks, heater control and ready flags.
// An input transfer reaches its result through the input register and the result register.
// Throughput: one tick per cycle unless the output stalls; the state update is a
// single pass of constant multiplies and compares between input and result registers.
// Reset (rst, synchronous): disarmed, heater off, all timers and accumulators zero,
// configuration registers at their documented defaults.
module armed_boiler_thermostat_unit import abt_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  abt_in_if.sink                in_ch,
  abt_out_if.source             out_ch,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data
);

  // Wide enough for raw * 33000 and for a 19-bit limit shifted by ADC_BITS.
  localparam int SW = ADC_BITS + 20;
  localparam logic [SW-1:0]        SCALE_W       = SW'(TEMP_SCALE);
  localparam logic signed [SW-1:0] OFFSET_SCALED = SW'(TEMP_OFFSET * (2 ** ADC_BITS));

  // Configuration registers
  logic signed [TEMP_W-1:0] boiler_sp;
  logic signed [TEMP_W-1:0] left_sp;
  logic signed [TEMP_W-1:0] right_sp;
  logic signed [TEMP_W-1:0] error_limit;
  logic [TIME_W-1:0]        max_armed;

  always_ff @(posedge clk) begin
    if (rst) begin
      boiler_sp   <= BOILER_SP_RESET;
      left_sp     <= LEFT_SP_RESET;
      right_sp    <= RIGHT_SP_RESET;
      error_limit <= ERROR_LIMIT_RESET;
      max_armed   <= MAX_ARMED_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_BOILER_SP:   boiler_sp   <= wr_data[TEMP_W-1:0];
        REG_LEFT_SP:     left_sp     <= wr_data[TEMP_W-1:0];
        REG_RIGHT_SP:    right_sp    <= wr_data[TEMP_W-1:0];
        REG_ERROR_LIMIT: error_limit <= wr_data[TEMP_W-1:0];
        REG_MAX_ARMED:   max_armed   <= wr_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                s0_valid;
  logic                advance;
  logic [TIME_W-1:0]   now_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [ADC_BITS-1:0] raw_q [NUM_PROBES];

  assign advance     = s0_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s0_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      now_q    <= in_ch.now_ms;
      level_q  <= in_ch.switch_level;
      raw_q[0] <= in_ch.boiler_raw;
      raw_q[1] <= in_ch.left_group_raw;
      raw_q[2] <= in_ch.right_group_raw;
      raw_q[3] <= in_ch.case_upper_raw;
      raw_q[4] <= in_ch.case_lower_raw;
      raw_q[5] <= in_ch.outside_raw;
    end
  end

  // Controller state
  logic              armed;
  logic              heater_state;
  logic [TIME_W-1:0] last_toggle_ms;
  logic [TIME_W-1:0] armed_time_ms;
  logic [TIME_W-1:0] heater_start_ms;
  logic [TIME_W-1:0] heater_accum_ms;

  logic              armed_next;
  logic              heater_state_next;
  logic [TIME_W-1:0] last_toggle_ms_next;
  logic [TIME_W-1:0] armed_time_ms_next;
  logic [TIME_W-1:0] heater_start_ms_next;
  logic [TIME_W-1:0] heater_accum_ms_next;

  // Probe conversion
  logic signed [SW-1:0] scaled [NUM_PROBES];
  logic signed [SW-1:0] temp   [3];
  logic signed [SW-1:0] limit_scaled;
  logic [NUM_PROBES-1:0] probe_err;

  assign limit_scaled = SW'(error_limit) <<< ADC_BITS;

  always_comb begin
    for (int i = 0; i < NUM_PROBES; i++) begin
      scaled[i]    = $signed(SW'(raw_q[i]) * SCALE_W) - OFFSET_SCALED;
      probe_err[i] = scaled[i] > limit_scaled;
    end
    // Truncation toward zero: an arithmetic shift rounds down, so negative
    // values with a fractional part move up by one.
    for (int i = 0; i < 3; i++) begin
      temp[i] = scaled[i] >>> ADC_BITS;
      if (scaled[i][SW-1] && (|scaled[i][ADC_BITS-1:0])) begin
        temp[i] = temp[i] + SW'(1);
      end
    end
  end

  logic              toggle;
  logic              armed_a;
  logic              armed_b;
  logic [TIME_W-1:0] last_a;
  logic [TIME_W-1:0] last_b;
  logic [TIME_W-1:0] armed_time_a;
  logic              fault;
  logic              active;
  logic              b_ready;
  logic              l_ready;
  logic              r_ready;
  logic [TIME_W-1:0] total;

  always_comb begin
    toggle = (level_q < SWITCH_PRESSED_BELOW) && ((now_q - last_toggle_ms) > DEBOUNCE_MS);

    armed_a      = toggle ? !armed : armed;
    last_a       = toggle ? now_q : last_toggle_ms;
    armed_time_a = (toggle && armed) ? '0 : armed_time_ms;

    // Overlong armed period, judged on the armed time left by the previous tick
    armed_b = armed_a;
    last_b  = last_a;
    if (armed_a && (armed_time_a > max_armed)) begin
      armed_b = 1'b0;
      last_b  = now_q;
    end

    fault = armed_b && (|probe_err);

    armed_next          = armed_b && !fault;
    last_toggle_ms_next = fault ? now_q : last_b;
    armed_time_ms_next  = armed_next ? (now_q - last_toggle_ms_next) : '0;

    active               = 1'b0;
    heater_state_next    = heater_state;
    heater_start_ms_next = heater_start_ms;
    heater_accum_ms_next = heater_accum_ms;
    if (armed_next && (temp[0] < SW'(boiler_sp))) begin
      active = 1'b1;
      if (!heater_state) begin
        heater_state_next    = 1'b1;
        heater_start_ms_next = now_q;
      end
    end else if (heater_state) begin
      heater_state_next    = 1'b0;
      heater_accum_ms_next = heater_accum_ms + (now_q - heater_start_ms);
    end

    b_ready = temp[0] > SW'(boiler_sp);
    l_ready = temp[1] > SW'(left_sp);
    r_ready = temp[2] > SW'(right_sp);

    total = heater_accum_ms_next;
    if (heater_state_next) begin
      total = total + (now_q - heater_start_ms_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      heater_state    <= 1'b0;
      last_toggle_ms  <= '0;
      armed_time_ms   <= '0;
      heater_start_ms <= '0;
      heater_accum_ms <= '0;
    end else if (advance) begin
      armed           <= armed_next;
      heater_state    <= heater_state_next;
      last_toggle_ms  <= last_toggle_ms_next;
      armed_time_ms   <= armed_time_ms_next;
      heater_start_ms <= heater_start_ms_next;
      heater_accum_ms <= heater_accum_ms_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.heater_on        <= heater_state_next;
      out_ch.is_armed         <= armed_next;
      out_ch.is_active        <= active;
      out_ch.boiler_ready     <= b_ready;
      out_ch.left_ready       <= l_ready;
      out_ch.right_ready      <= r_ready;
      out_ch.system_ready     <= armed_next && b_ready && l_ready && r_ready;
      out_ch.sensor_fault     <= fault;
      out_ch.armed_elapsed_ms <= armed_time_ms_next;
      out_ch.heater_total_ms  <= total;
      out_ch.boiler_temp      <= temp[0][TEMP_OUT_W-1:0];
    end
  end

endmodule
